// ===== rtl/clns_pkg.sv =====
// Package for the character LCD nibble sequencer: word types, codes, step tables
// and the step decode functions. Depends on nothing else.
package clns_pkg;

    // Width of the wait counter; configured waits above its range saturate.
    localparam int WAIT_BITS = 16;
    localparam logic [32:0] WAIT_LIM = (33'd1 << WAIT_BITS) - 33'd1;

    // Command codes carried in the func field.
    localparam logic [1:0] FN_TICK = 2'd0;
    localparam logic [1:0] FN_INIT = 2'd1;
    localparam logic [1:0] FN_INST = 2'd2;
    localparam logic [1:0] FN_DATA = 2'd3;

    // Sequencer modes; the command modes share the command codes.
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_INIT = 2'd1;
    localparam logic [1:0] MODE_INST = 2'd2;
    localparam logic [1:0] MODE_DATA = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_POWER  = 3'd0;
    localparam logic [2:0] CFG_LONG   = 3'd1;
    localparam logic [2:0] CFG_SHORT  = 3'd2;
    localparam logic [2:0] CFG_RECOV  = 3'd3;
    localparam logic [2:0] CFG_INST   = 3'd4;
    localparam logic [2:0] CFG_DATA   = 3'd5;
    localparam logic [2:0] CFG_STROBE = 3'd6;

    // Kinds of wait that a step loads.
    localparam logic [2:0] WK_POWER  = 3'd0;
    localparam logic [2:0] WK_LONG   = 3'd1;
    localparam logic [2:0] WK_SHORT  = 3'd2;
    localparam logic [2:0] WK_RECOV  = 3'd3;
    localparam logic [2:0] WK_STROBE = 3'd4;
    localparam logic [2:0] WK_INST   = 3'd5;
    localparam logic [2:0] WK_DATA   = 3'd6;

    // Pin word bits.
    localparam logic [6:0] PIN_EN = 7'h40;
    localparam logic [6:0] PIN_RS = 7'h20;

    // Init sequence: the head of raw pulses, then the set-up instruction bytes.
    localparam int INIT_HEAD  = 15;
    localparam int INIT_BYTES = 5;
    localparam int BYTE_STEPS = 5;

    localparam logic [6:0] INIT_PINS [INIT_HEAD] = '{
        7'h00, 7'h03, 7'h43, 7'h03, 7'h03, 7'h03, 7'h43, 7'h03,
        7'h03, 7'h03, 7'h43, 7'h03, 7'h03, 7'h43, 7'h03
    };
    localparam logic [2:0] INIT_WAITS [INIT_HEAD] = '{
        WK_POWER, WK_STROBE, WK_STROBE, WK_RECOV, WK_LONG,
        WK_STROBE, WK_STROBE, WK_RECOV, WK_SHORT,
        WK_STROBE, WK_STROBE, WK_RECOV,
        WK_STROBE, WK_STROBE, WK_RECOV
    };
    localparam logic [7:0] INIT_CODES [INIT_BYTES] = '{
        8'h28, 8'h06, 8'h08, 8'h0F, 8'h01
    };

    // One input word.
    typedef struct packed {
        logic [1:0] func;
        logic [7:0] byte_value;
    } cmd_t;

    // One result word.
    typedef struct packed {
        logic [6:0] lcd_pins;
        logic       busy_res;
        logic       rejected;
        logic       sequence_done;
    } res_t;

    // Decoded step: whether it exists, its pin word and its wait kind.
    typedef struct packed {
        logic       ok;
        logic [6:0] pin;
        logic [2:0] kind;
    } step_t;

    // Clamp a configured wait to the counter width.
    function automatic logic [WAIT_BITS-1:0] sat_wait(logic [15:0] v);
        logic [32:0] wide;
        wide = 33'(v);
        if (wide > WAIT_LIM)
            return '1;
        else
            return WAIT_BITS'(wide);
    endfunction

    // One of the five pin writes of a byte. The low nibble has no leading
    // write without enable, so it strobes with enable then data alone.
    function automatic step_t byte_step(logic [7:0] b, logic [2:0] j, logic rs,
                                        logic [2:0] settle);
        step_t      s;
        logic [6:0] hi;
        logic [6:0] lo;
        logic [6:0] p;
        hi = {3'b000, b[7:4]};
        lo = {3'b000, b[3:0]};
        case (j)
            3'd0:    p = hi;
            3'd1:    p = PIN_EN | hi;
            3'd2:    p = hi;
            3'd3:    p = PIN_EN | lo;
            default: p = lo;
        endcase
        s.ok   = 1'b1;
        s.pin  = p | (rs ? PIN_RS : 7'h00);
        s.kind = (j == 3'd4) ? settle : WK_STROBE;
        return s;
    endfunction

    // Step idx of a sequence in the given mode; ok is low past its end.
    function automatic step_t step_desc(logic [1:0] mode, logic [5:0] idx,
                                        logic [7:0] latched);
        step_t      s;
        logic [5:0] r;
        logic [2:0] q;
        logic [2:0] j;
        s = '0;
        r = '0;
        q = '0;
        j = '0;
        unique case (mode) inside
            MODE_INIT:
            begin
                if (idx < 6'(INIT_HEAD))
                begin
                    s.ok   = 1'b1;
                    s.pin  = INIT_PINS[idx[3:0]];
                    s.kind = INIT_WAITS[idx[3:0]];
                end
                else
                begin
                    r = idx - 6'(INIT_HEAD);
                    if (r < 6'(INIT_BYTES * BYTE_STEPS))
                    begin
                        // Split the offset into byte number and step within it.
                        for (int k = 0; k < INIT_BYTES; k++)
                        begin
                            if (r >= 6'(BYTE_STEPS * k))
                            begin
                                q = 3'(k);
                                j = 3'(r - 6'(BYTE_STEPS * k));
                            end
                        end
                        s = byte_step(INIT_CODES[q], j, 1'b0, WK_INST);
                    end
                end
            end
            MODE_INST, MODE_DATA:
            begin
                if (idx < 6'(BYTE_STEPS))
                    s = byte_step(latched, idx[2:0], mode == MODE_DATA,
                                  (mode == MODE_DATA) ? WK_DATA : WK_INST);
            end
            default:
            begin
                s = '0;
            end
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/char_lcd_nibble_sequencer.sv =====
// Top level of the character LCD nibble sequencer: sequencer state, wait counter,
// configuration registers and result register. Depends on clns_pkg.

// Each input word is a microsecond tick or a command (init sequence, instruction
// byte, data byte) and yields exactly one result word carrying the pin word, busy,
// rejected and sequence-done flags. A word is taken every clock cycle: the whole
// step decode and the wait counter update sit between the state registers and a
// single result register, so the only thing that holds the input back is a result
// still waiting in that register while the output side stalls. Commands that arrive
// while a sequence or wait runs are dropped and flagged as rejected. Configuration
// writes are taken at any cycle but are meant to be made while the block is idle.
module char_lcd_nibble_sequencer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  clns_pkg::cmd_t       cmd,
    output logic                 res_valid,
    input  logic                 res_stall,
    output clns_pkg::res_t       res,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_data
);
    import clns_pkg::*;

    // Configuration registers.
    logic [15:0] power_on_wait_reg;
    logic [15:0] init_gap_long_reg;
    logic [15:0] init_gap_short_reg;
    logic [15:0] init_pulse_recovery_reg;
    logic [15:0] inst_settle_reg;
    logic [15:0] data_settle_reg;
    logic [7:0]  strobe_ticks_reg;

    // Sequencer state.
    logic [1:0]           mode_reg, mode_next;
    logic [5:0]           step_reg, step_next;
    logic [WAIT_BITS-1:0] wait_reg, wait_next;
    logic [6:0]           pin_reg, pin_next;
    logic [7:0]           byte_reg, byte_next;

    // Result register.
    logic res_valid_reg, res_valid_next;
    res_t res_reg, res_next;

    logic  cmd_acc;
    logic  rej;
    logic  done;
    step_t nxt;
    step_t first;

    assign cmd_stall = res_valid_reg & res_stall;
    assign cmd_acc   = cmd_valid & ~cmd_stall;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Wait value that a step of the given kind loads.
    function automatic logic [WAIT_BITS-1:0] wait_of(logic [2:0] kind);
        logic [15:0] v;
        unique case (kind)
            WK_POWER: v = power_on_wait_reg;
            WK_LONG:  v = init_gap_long_reg;
            WK_SHORT: v = init_gap_short_reg;
            WK_RECOV: v = init_pulse_recovery_reg;
            WK_INST:  v = inst_settle_reg;
            WK_DATA:  v = data_settle_reg;
            default:  v = {8'h00, strobe_ticks_reg};
        endcase
        return sat_wait(v);
    endfunction

    // Configuration writes; an index past the last register is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_on_wait_reg       <= 16'd15000;
            init_gap_long_reg       <= 16'd4100;
            init_gap_short_reg      <= 16'd100;
            init_pulse_recovery_reg <= 16'd1000;
            inst_settle_reg         <= 16'd500;
            data_settle_reg         <= 16'd250;
            strobe_ticks_reg        <= 8'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POWER:  power_on_wait_reg       <= cfg_data;
                CFG_LONG:   init_gap_long_reg       <= cfg_data;
                CFG_SHORT:  init_gap_short_reg      <= cfg_data;
                CFG_RECOV:  init_pulse_recovery_reg <= cfg_data;
                CFG_INST:   inst_settle_reg         <= cfg_data;
                CFG_DATA:   data_settle_reg         <= cfg_data;
                CFG_STROBE: strobe_ticks_reg        <= cfg_data[7:0];
                default:    ;
            endcase
        end
    end

    // Step decode for the tick and command paths.
    assign nxt   = step_desc(mode_reg, step_reg + 6'd1, byte_reg);
    assign first = step_desc(cmd.func, 6'd0,
                             (cmd.func != FN_INIT) ? cmd.byte_value : byte_reg);

    // Next state of the sequencer for an accepted word.
    always_comb
    begin
        mode_next = mode_reg;
        step_next = step_reg;
        wait_next = wait_reg;
        pin_next  = pin_reg;
        byte_next = byte_reg;
        rej       = 1'b0;
        done      = 1'b0;
        if (cmd_acc)
        begin
            if (cmd.func == FN_TICK)
            begin
                if (mode_reg != MODE_IDLE)
                begin
                    if (wait_reg > WAIT_BITS'(1))
                    begin
                        wait_next = wait_reg - WAIT_BITS'(1);
                    end
                    else if (nxt.ok)
                    begin
                        step_next = step_reg + 6'd1;
                        pin_next  = nxt.pin;
                        wait_next = wait_of(nxt.kind);
                    end
                    else
                    begin
                        // Last step finished: go idle, keep the pin word.
                        mode_next = MODE_IDLE;
                        step_next = '0;
                        wait_next = '0;
                        done      = 1'b1;
                    end
                end
            end
            else if (mode_reg != MODE_IDLE)
            begin
                rej = 1'b1;
            end
            else
            begin
                if (cmd.func != FN_INIT)
                    byte_next = cmd.byte_value;
                mode_next = cmd.func;
                step_next = '0;
                pin_next  = first.pin;
                wait_next = wait_of(first.kind);
            end
        end
    end

    // Result word for the accepted input word.
    always_comb
    begin
        res_next.lcd_pins      = pin_next;
        res_next.busy_res      = (mode_next != MODE_IDLE);
        res_next.rejected      = rej;
        res_next.sequence_done = done;
        if (cmd_acc)
            res_valid_next = 1'b1;
        else
            res_valid_next = res_valid_reg & res_stall;
    end

    // Sequencer state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            step_reg      <= '0;
            wait_reg      <= '0;
            pin_reg       <= '0;
            byte_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            step_reg      <= step_next;
            wait_reg      <= wait_next;
            pin_reg       <= pin_next;
            byte_reg      <= byte_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Result payload loads only when a word is accepted.
    always_ff @(posedge clk)
    begin
        if (cmd_acc)
            res_reg <= res_next;
    end

    // A rejected command never comes with an idle sequencer.
    a_rej_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.rejected) |-> res.busy_res)
        else $error("rejected result reported while not busy");

    // The end of a sequence leaves the block idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.sequence_done) |-> !res.busy_res)
        else $error("sequence done reported while still busy");

    // An idle sequencer holds a cleared step index and wait counter.
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_IDLE) |-> (step_reg == '0 && wait_reg == '0))
        else $error("idle sequencer with stale step or wait");

    // A command taken while busy is flagged in the next result.
    a_busy_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_acc && cmd.func != FN_TICK && mode_reg != MODE_IDLE)
        |=> (res_valid && res.rejected))
        else $error("command taken while busy was not rejected");

endmodule

// ===== bench/char_lcd_nibble_sequencer_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the character LCD nibble sequencer: a scoreboard class predicts
// every result word, plain tasks drive commands, ticks and register writes. Uses clns_pkg.
module char_lcd_nibble_sequencer_test;
    import clns_pkg::*;

    // No acceptance on either side for this many cycles ends the run. The longest correct
    // quiet stretch is the deliberate output hold-off plus a few random gaps.
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    // Index past the last register; writes to it must be ignored.
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    // Predicts the pin word and the flags that every command or tick word produces.
    class lcd_sequencer_scoreboard;
        logic [15:0] wait_cfg [7];
        logic [6:0]  pin_word;
        logic [5:0]  step_idx;
        logic [15:0] wait_cnt;
        logic [7:0]  latched;
        logic [1:0]  mode;
        res_t        pin_reports [$];
        int          errors;

        function new();
            wait_cfg[CFG_POWER]  = 16'd15000;
            wait_cfg[CFG_LONG]   = 16'd4100;
            wait_cfg[CFG_SHORT]  = 16'd100;
            wait_cfg[CFG_RECOV]  = 16'd1000;
            wait_cfg[CFG_INST]   = 16'd500;
            wait_cfg[CFG_DATA]   = 16'd250;
            wait_cfg[CFG_STROBE] = 16'd1;
            pin_word = '0;
            step_idx = '0;
            wait_cnt = '0;
            latched  = '0;
            mode     = MODE_IDLE;
            errors   = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] v);
            if (idx < CFG_STROBE)
                wait_cfg[idx] = v;
            else if (idx == CFG_STROBE)
                wait_cfg[idx] = {8'h00, v[7:0]};
        endfunction

        function bit busy();
            return mode != MODE_IDLE;
        endfunction

        function int pending();
            return pin_reports.size();
        endfunction

        // Pin word and wait of step idx in the current mode; returns 0 past the end.
        function bit step_of(logic [5:0] idx, output logic [6:0] pin, output logic [15:0] wt);
            logic [7:0] b;
            logic [6:0] p;
            logic [6:0] rs;
            logic [2:0] settle;
            logic [2:0] reg_sel;
            int         j;
            int         k;
            pin = '0;
            wt  = '0;
            rs  = '0;
            settle = CFG_INST;
            if (mode == MODE_INIT)
            begin
                // The fifteen raw init steps: power-on wait, then four 0x3 pulses.
                if (idx < 6'd15)
                begin
                    case (idx)
                        6'd0:                      begin p = 7'h00; reg_sel = CFG_POWER;  end
                        6'd2, 6'd6, 6'd10, 6'd13: begin p = 7'h43; reg_sel = CFG_STROBE; end
                        6'd3, 6'd7, 6'd11, 6'd14: begin p = 7'h03; reg_sel = CFG_RECOV;  end
                        6'd4:                      begin p = 7'h03; reg_sel = CFG_LONG;   end
                        6'd8:                      begin p = 7'h03; reg_sel = CFG_SHORT;  end
                        default:                   begin p = 7'h03; reg_sel = CFG_STROBE; end
                    endcase
                    pin = p;
                    wt  = wait_cfg[reg_sel];
                    return 1'b1;
                end
                // Then five set-up instruction bytes of five steps each.
                k = int'(idx) - 15;
                if (k >= 25)
                    return 1'b0;
                case (k / 5)
                    0:       b = 8'h28;
                    1:       b = 8'h06;
                    2:       b = 8'h08;
                    3:       b = 8'h0F;
                    default: b = 8'h01;
                endcase
                j = k % 5;
            end
            else if (mode == MODE_INST || mode == MODE_DATA)
            begin
                if (idx >= 6'd5)
                    return 1'b0;
                b = latched;
                j = int'(idx);
                if (mode == MODE_DATA)
                begin
                    rs = PIN_RS;
                    settle = CFG_DATA;
                end
            end
            else
                return 1'b0;

            // High nibble gets a full strobe, the low nibble only enable then data.
            case (j)
                0:       p = {3'b000, b[7:4]};
                1:       p = PIN_EN | {3'b000, b[7:4]};
                2:       p = {3'b000, b[7:4]};
                3:       p = PIN_EN | {3'b000, b[3:0]};
                default: p = {3'b000, b[3:0]};
            endcase
            pin = p | rs;
            wt  = (j == 4) ? wait_cfg[settle] : wait_cfg[CFG_STROBE];
            return 1'b1;
        endfunction

        // Advances the predicted sequencer by one accepted word and queues its result.
        function void note_input(cmd_t w);
            res_t        e;
            logic [6:0]  p;
            logic [15:0] wt;
            bit          rej;
            bit          done;
            rej  = 1'b0;
            done = 1'b0;
            if (w.func == FN_TICK)
            begin
                if (mode != MODE_IDLE)
                begin
                    if (wait_cnt > 16'd1)
                        wait_cnt--;
                    else if (step_of(step_idx + 6'd1, p, wt))
                    begin
                        step_idx++;
                        pin_word = p;
                        wait_cnt = wt;
                    end
                    else
                    begin
                        mode     = MODE_IDLE;
                        step_idx = '0;
                        wait_cnt = '0;
                        done     = 1'b1;
                    end
                end
            end
            else if (mode != MODE_IDLE)
                rej = 1'b1;
            else
            begin
                if (w.func != FN_INIT)
                    latched = w.byte_value;
                mode     = w.func;
                step_idx = '0;
                void'(step_of(6'd0, p, wt));
                pin_word = p;
                wait_cnt = wt;
            end
            e.lcd_pins      = pin_word;
            e.busy_res      = (mode != MODE_IDLE);
            e.rejected      = rej;
            e.sequence_done = done;
            pin_reports.push_back(e);
        endfunction

        function void compare_field(string name, logic [6:0] want, logic [6:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        // Compares an accepted result word with the oldest prediction.
        function void check_result(res_t got);
            res_t e;
            if (pin_reports.size() == 0)
            begin
                $error("result word with no prediction waiting: %0h", got);
                errors++;
                return;
            end
            e = pin_reports.pop_front();
            compare_field("lcd_pins", e.lcd_pins, got.lcd_pins);
            compare_field("busy_res", 7'(e.busy_res), 7'(got.busy_res));
            compare_field("rejected", 7'(e.rejected), 7'(got.rejected));
            compare_field("sequence_done", 7'(e.sequence_done), 7'(got.sequence_done));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_stall;
    cmd_t        cmd = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    res_t        res;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    lcd_sequencer_scoreboard sb;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit long_hold = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;

    char_lcd_nibble_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Output side: check accepted words, then stall at random or for a long hold-off.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            sb.check_result(res);
        if (long_hold)
        begin
            long_hold = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_stall <= 1'b1;
        end
        else
            res_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog on cycles in which neither side moves a word.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Offers one word, with random idle cycles ahead of it, and holds it until taken.
    task automatic send_word(logic [1:0] f, logic [7:0] b);
        cmd_t w;
        w.func = f;
        w.byte_value = b;
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= w;
        do
            @(posedge clk);
        while (cmd_stall);
        sb.note_input(w);
    endtask

    // Ticks the running sequence to its end and waits until every result is in.
    task automatic run_out();
        while (sb.busy())
            send_word(FN_TICK, 8'($urandom));
        cmd_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Writes every register with values from the given ranges, plus the unused index.
    task automatic program_regs(int wlo, int whi, int slo, int shi);
        logic [15:0] v;
        for (int i = int'(CFG_POWER); i <= int'(CFG_UNUSED); i++)
        begin
            if (i == int'(CFG_STROBE))
                v = {8'($urandom), 8'($urandom_range(shi, slo))};
            else
                v = 16'($urandom_range(whi, wlo));
            cfg_we <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data <= v;
            @(posedge clk);
            sb.write_reg(3'(i), v);
        end
        cfg_we <= 1'b0;
    endtask

    // Mostly complete sequences with random bytes, plus idle ticks and commands while busy.
    task automatic run_traffic(int budget);
        int r;
        logic [1:0] f;
        for (int n = 0; n < budget; n++)
        begin
            r = $urandom_range(99);
            if (!sb.busy())
                f = (r < 8) ? FN_TICK : (r < 22) ? FN_INIT : (r < 60) ? FN_INST : FN_DATA;
            else
                f = (r < 6) ? 2'($urandom_range(FN_DATA, FN_INIT)) : FN_TICK;
            send_word(f, 8'($urandom));
        end
    endtask

    initial
    begin
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset register values: one data byte, with commands refused while it runs.
        send_word(FN_DATA, 8'hC3);
        send_word(FN_INST, 8'hFF);
        send_word(FN_INIT, 8'h00);
        run_out();

        // Zero waits: every step still lasts one tick.
        program_regs(0, 0, 1, 1);
        send_word(FN_TICK, 8'hFF);
        send_word(FN_INST, 8'h00);
        run_out();
        send_word(FN_DATA, 8'hA5);
        send_word(FN_INIT, 8'h5A);
        send_word(FN_DATA, 8'hFF);
        run_out();
        send_word(FN_INIT, 8'h00);
        run_out();
        send_word(FN_TICK, 8'h00);
        run_out();

        // Random traffic with no idling on either side.
        program_regs(0, 3, 1, 2);
        run_traffic(300);
        run_out();

        // Sender idle most of the time.
        send_idle_pct = 62;
        program_regs(0, 8, 1, 4);
        run_traffic(300);
        run_out();

        // Receiver stalling, with one long hold-off while words keep coming.
        send_idle_pct = 0;
        recv_stall_pct = 62;
        program_regs(0, 5, 1, 3);
        run_traffic(150);
        long_hold = 1'b1;
        run_traffic(150);
        run_out();

        // Light idling on both sides, with a pause until every result is in.
        send_idle_pct = 11;
        recv_stall_pct = 11;
        program_regs(0, 6, 1, 3);
        run_traffic(150);
        cmd_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        run_traffic(150);
        run_out();

        repeat (4) @(posedge clk);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
